// ===== sv/wsra_pkg.sv =====
// ----------------------------------------------------------------------------
// wsra_pkg: shared types and constants
// State encodings and fixed field widths for the send-rate averager.
// ----------------------------------------------------------------------------
package wsra_pkg;

  localparam int SAMPLE_W  = 32;   // delay and byte fields
  localparam int RATE_W    = 46;   // reported rate
  localparam int WIN_W     = 5;    // window_len register
  localparam int SCALE_W   = 10;   // width of the ms-to-s factor

  localparam logic [WIN_W-1:0]   WIN_RESET  = 5'd16;
  localparam logic [SCALE_W-1:0] MS_PER_SEC = 10'd1000;

  typedef enum logic {
    F_IDLE,
    F_WORK
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ===== sv/windowed_send_rate_averager.sv =====
// ----------------------------------------------------------------------------
// windowed_send_rate_averager: sliding-window send throughput average
// Keeps the latest send samples and reports bytes per second over them.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one send sample per word: delay in ms and byte count.
//   m_axis returns one word per sample: the average rate in bytes per
//   second over the samples now in the window (floor(bytes*1000/delay);
//   bytes*1000 when the delay sum is zero; zero when the byte sum is zero).
//   cfg_we/cfg_wdata set window_len (0 acts as 1, above MAX_POINTS clips);
//   write it only while no sample is in flight.
// Timing:
//   A sample is registered when taken and folded into the window sums once
//   the queue has room; the sums then cross a two-entry queue to the
//   divider, which loads them, works one dividend bit per cycle (SUM_W + 10,
//   46 at MAX_POINTS = 16) and registers the result. The front takes new
//   samples while the divider works, as long as the queue has room. A zero
//   delay sum skips the divide.
// Reset:
//   rst (synchronous) empties the window, zeroes the sums, sets window_len
//   to 16 and drops m_axis_tvalid.
// Stall:
//   With m_axis_tready low the result is held; one more sample finishes in
//   the divider, two wait in the queue and one in the front, then
//   s_axis_tready stays low.
// ----------------------------------------------------------------------------
module windowed_send_rate_averager #(
  parameter int MAX_POINTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [wsra_pkg::WIN_W-1:0]  cfg_wdata,     // window_len
  // sample input
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,  // delay_ms[31:0], byte_count[63:32]
  // rate output
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata   // rate_bytes_per_sec[45:0], zero pad
);

  localparam int SUM_W = wsra_pkg::SAMPLE_W + $clog2(MAX_POINTS);

  logic [wsra_pkg::WIN_W-1:0]  window_len;
  logic                        q_full, q_empty, q_push, q_pop;
  logic [2*SUM_W-1:0]          q_in, q_head;
  logic [wsra_pkg::RATE_W-1:0] rate;

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= wsra_pkg::WIN_RESET;
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
    end
  end

  // front: intake, eviction, ring update, running sums
  wsra_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .delay_ms   (s_axis_tdata[31:0]),
    .byte_count (s_axis_tdata[63:32]),
    .window_len (window_len),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // decouples the short front pass from the long divide
  wsra_queue #(
    .WIDTH(2*SUM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: scale, divide, hold result
  wsra_back #(
    .SUM_W(SUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .rate      (rate)
  );

  assign m_axis_tdata = {2'b00, rate};

endmodule

// ===== sv/wsra_ram.sv =====
// ----------------------------------------------------------------------------
// wsra_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wsra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/wsra_front.sv =====
// ----------------------------------------------------------------------------
// wsra_front: sample intake and window bookkeeping
// Accepts a sample, evicts the oldest entry when the window is full, stores
// the new one and pushes the updated byte and delay sums to the queue.
// ----------------------------------------------------------------------------
module wsra_front #(
  parameter int MAX_POINTS = 16,
  localparam int SUM_W = wsra_pkg::SAMPLE_W + $clog2(MAX_POINTS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wsra_pkg::SAMPLE_W-1:0] delay_ms,
  input  logic [wsra_pkg::SAMPLE_W-1:0] byte_count,
  input  logic [wsra_pkg::WIN_W-1:0]    window_len,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [2*SUM_W-1:0]            q_data   // delay_sum low, bytes_sum high
);

  localparam int SW    = wsra_pkg::SAMPLE_W;
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int EW    = (CNT_W > wsra_pkg::WIN_W) ? CNT_W : wsra_pkg::WIN_W;

  wsra_pkg::front_state_t state, state_next;

  logic [SW-1:0]    d_in, b_in;
  logic [IDX_W-1:0] oldest_slot;
  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] delay_sum, bytes_sum;

  logic [2*SW-1:0]  rd_data;
  logic             evict;
  logic [EW-1:0]    win_ext, win_eff;
  logic [IDX_W-1:0] oldest_ev, slot;
  logic [CNT_W-1:0] count_ev;
  logic [CNT_W:0]   slot_sum;
  logic [SUM_W-1:0] dsum_new, bsum_new;
  logic             accept, commit;

  // ring holds {byte_count, delay_ms}; read port always points at the oldest
  wsra_ram #(
    .WIDTH(2*SW),
    .DEPTH(MAX_POINTS)
  ) u_ring (
    .clk   (clk),
    .we    (commit),
    .waddr (slot),
    .wdata ({b_in, d_in}),
    .raddr (oldest_slot),
    .rdata (rd_data)
  );

  // effective window: zero reads as one, clipped to ring depth
  always_comb begin
    win_ext = EW'(window_len);
    if (window_len == '0) begin
      win_eff = EW'(1);
    end else if (win_ext > EW'(MAX_POINTS)) begin
      win_eff = EW'(MAX_POINTS);
    end else begin
      win_eff = win_ext;
    end
  end

  always_comb begin
    evict     = (EW'(sample_count) >= win_eff) && (sample_count != '0);
    count_ev  = evict ? sample_count - CNT_W'(1) : sample_count;
    oldest_ev = oldest_slot;
    if (evict) begin
      oldest_ev = (oldest_slot == IDX_W'(MAX_POINTS - 1)) ? '0 : oldest_slot + IDX_W'(1);
    end
    slot_sum = (CNT_W+1)'(oldest_ev) + (CNT_W+1)'(count_ev);
    if (slot_sum >= (CNT_W+1)'(MAX_POINTS)) begin
      slot = IDX_W'(slot_sum - (CNT_W+1)'(MAX_POINTS));
    end else begin
      slot = IDX_W'(slot_sum);
    end
    dsum_new = (evict ? delay_sum - SUM_W'(rd_data[SW-1:0]) : delay_sum) + SUM_W'(d_in);
    bsum_new = (evict ? bytes_sum - SUM_W'(rd_data[2*SW-1:SW]) : bytes_sum) + SUM_W'(b_in);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wsra_pkg::F_IDLE: if (in_valid) state_next = wsra_pkg::F_WORK;
      wsra_pkg::F_WORK: if (!q_full)  state_next = wsra_pkg::F_IDLE;
      default:          state_next = wsra_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    unique case (state)
      wsra_pkg::F_IDLE: in_ready = 1'b1;
      wsra_pkg::F_WORK: commit   = !q_full;
      default:          in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;
  assign q_push = commit;
  assign q_data = {bsum_new, dsum_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wsra_pkg::F_IDLE;
      oldest_slot  <= '0;
      sample_count <= '0;
      delay_sum    <= '0;
      bytes_sum    <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        oldest_slot  <= oldest_ev;
        sample_count <= count_ev + CNT_W'(1);
        delay_sum    <= dsum_new;
        bytes_sum    <= bsum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_in <= delay_ms;
      b_in <= byte_count;
    end
  end

endmodule

// ===== sv/wsra_queue.sv =====
// ----------------------------------------------------------------------------
// wsra_queue: two-entry FIFO
// Holds updated sums between the window front end and the divider.
// ----------------------------------------------------------------------------
module wsra_queue #(
  parameter int WIDTH = 72
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/wsra_back.sv =====
// ----------------------------------------------------------------------------
// wsra_back: rate divider and output register
// Scales the byte sum by 1000, divides by the delay sum one bit per cycle
// (skipped for a zero delay sum) and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsra_back #(
  parameter int SUM_W = 36
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2*SUM_W-1:0]          head,    // delay_sum low, bytes_sum high
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wsra_pkg::RATE_W-1:0] rate
);

  localparam int DIV_W  = SUM_W + wsra_pkg::SCALE_W;
  localparam int STEP_W = $clog2(DIV_W);

  wsra_pkg::back_state_t state, state_next;

  logic [SUM_W-1:0]  divisor, rem;
  logic [DIV_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [SUM_W:0]    rem_sh, diff;
  logic              load_out, last_step;

  assign rem_sh    = {rem, quo[DIV_W-1]};
  assign diff      = rem_sh - {1'b0, divisor};
  assign last_step = (step == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wsra_pkg::B_IDLE: begin
        if (!empty) begin
          state_next = (head[SUM_W-1:0] == '0) ? wsra_pkg::B_DONE : wsra_pkg::B_DIV;
        end
      end
      wsra_pkg::B_DIV:  if (last_step) state_next = wsra_pkg::B_DONE;
      wsra_pkg::B_DONE: if (!out_valid || out_ready) state_next = wsra_pkg::B_IDLE;
      default:          state_next = wsra_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state)
      wsra_pkg::B_IDLE: pop      = !empty;
      wsra_pkg::B_DONE: load_out = !out_valid || out_ready;
      default:          pop      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsra_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // restoring division, quotient shifts in where the dividend shifts out;
  // a zero delay sum skips straight to the scaled byte sum
  always_ff @(posedge clk) begin
    if (pop) begin
      quo     <= DIV_W'(head[2*SUM_W-1:SUM_W]) * DIV_W'(wsra_pkg::MS_PER_SEC);
      divisor <= head[SUM_W-1:0];
      rem     <= '0;
      step    <= STEP_W'(DIV_W - 1);
    end else if (state == wsra_pkg::B_DIV) begin
      step <= step - STEP_W'(1);
      if (!diff[SUM_W]) begin
        rem <= diff[SUM_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SUM_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
    if (load_out) begin
      rate <= wsra_pkg::RATE_W'(quo);
    end
  end

endmodule

// ===== sv/wsra_checker.sv =====
// ----------------------------------------------------------------------------
// wsra_checker: port-level checks
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
module wsra_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before it was taken");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one sample at a time: intake closes right after a take
  a_in_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken back to back");

  // reset clears any pending result
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // padding bits of the rate word stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:46] == 2'b00)
    else $error("rate padding bits set");

endmodule

bind windowed_send_rate_averager wsra_checker u_wsra_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
